>>> hw/rtl/jeafx_pkg.sv
// Package: shared types, constants and helper functions for the JSON audio field extractor.
`timescale 1ns / 1ps
package jeafx_pkg;

  localparam int MaxNest   = 8;
  localparam int CountBits = 16;
  localparam int StackSize = MaxNest + 2;
  localparam int LevelBits = $clog2(StackSize + 1);
  localparam int IdxBits   = $clog2(StackSize);

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_char;
    logic [1:0]  verdict;
    logic [15:0] payload_length;
  } out_word_t;

  typedef enum logic [13:0] {
    PM_START       = 14'b00000000000001,
    PM_OBJ_FIRST   = 14'b00000000000010,
    PM_ARR_FIRST   = 14'b00000000000100,
    PM_KEY_START   = 14'b00000000001000,
    PM_STR         = 14'b00000000010000,
    PM_STR_ESC     = 14'b00000000100000,
    PM_STR_HEX     = 14'b00000001000000,
    PM_COLON       = 14'b00000010000000,
    PM_VALUE_START = 14'b00000100000000,
    PM_TOKEN       = 14'b00001000000000,
    PM_AFTER       = 14'b00010000000000,
    PM_TAIL        = 14'b00100000000000,
    PM_FAIL        = 14'b01000000000000,
    PM_EMPTY       = 14'b10000000000000
  } parse_mode_e;

  typedef enum logic [2:0] {
    SEL_NONE      = 3'd0,
    SEL_TYPE_VAL  = 3'd1,
    SEL_DELTA_VAL = 3'd2,
    SEL_KEY_ANY   = 3'd3,
    SEL_KEY_TYPE  = 3'd4,
    SEL_KEY_DELTA = 3'd5
  } match_sel_e;

  localparam logic [1:0] VerdictNone  = 2'd0;
  localparam logic [1:0] VerdictAudio = 2'd1;
  localparam logic [1:0] VerdictBad   = 2'd2;

  // parser state carried between bytes
  typedef struct packed {
    parse_mode_e           mode;
    logic [LevelBits-1:0]  level;
    logic [2:0]            key_pos;
    logic [4:0]            val_pos;
    logic [2:0]            hex_left;
    logic                  got_type;
    logic                  got_delta;
    logic                  audio_evt;
    logic                  delta_str;
    logic                  delta_bad;
    logic                  miss;
    logic                  str_key;
    match_sel_e            sel;
    match_sel_e            role;
  } pstate_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_b64(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9")
        || b == "+" || b == "/" || b == "=";
  endfunction

  function automatic logic [7:0] audio_chr(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "r";  5'd1: c = "e";  5'd2: c = "s";  5'd3: c = "p";
      5'd4: c = "o";  5'd5: c = "n";  5'd6: c = "s";  5'd7: c = "e";
      5'd8: c = ".";  5'd9: c = "a";  5'd10: c = "u"; 5'd11: c = "d";
      5'd12: c = "i"; 5'd13: c = "o"; 5'd14: c = "."; 5'd15: c = "d";
      5'd16: c = "e"; 5'd17: c = "l"; 5'd18: c = "t"; 5'd19: c = "a";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] type_chr(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "t"; 3'd1: c = "y"; 3'd2: c = "p"; 3'd3: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] delta_chr(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "l"; 3'd3: c = "t"; 3'd4: c = "a";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/json_event_audio_field_extractor.sv
// Top level: parser state, container stack and output register with skid entry.
//
// Usage: feed one JSON message byte per word on the input channel, is_last set on
// the final byte. Each accepted byte is parsed in the cycle it is accepted; a
// "delta" string character produces a payload word (kind 0) and the final byte
// produces exactly one verdict word (kind 1) with the saturated payload length.
// Words not producing a result are absorbed silently.
// A result word goes to the output register, or to the skid entry while stalled.
// Throughput: one byte per cycle while in_ready_o is high, set by the combinational
// parser step and the one-entry output register with a skid entry behind it.
// When the receiver stalls, the skid entry fills and in_ready_o drops until a
// word is taken; no word is lost or duplicated.
// Reset puts the parser at "expect opening brace" and empties both output
// entries; after each verdict the parser returns to that state by itself.
// The container stack has no reset; only entries below the nesting level are read.
`timescale 1ns / 1ps
module json_event_audio_field_extractor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  jeafx_pkg::in_word_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output jeafx_pkg::out_word_t  out_data_o
);
  import jeafx_pkg::*;

  pstate_t                       st_q, st_d, nxt;
  logic [StackSize-1:0]          kinds_q;
  logic [CountBits-1:0]          count_q, count_d;
  logic [1:0]                    phase_q, phase_d;
  logic                          push, push_obj, emit;
  logic                          acc;
  logic                          res_vld;
  out_word_t                     res;
  logic                          ov_q, sk_q;
  out_word_t                     od_q, sd_q;
  logic [1:0]                    verdict;
  pstate_t                       rst_st;

  assign rst_st = '{mode: PM_START, sel: SEL_NONE, role: SEL_NONE, default: '0};

  jeafx_parser u_parser (
    .cur_i      (st_q),
    .b_i        (in_data_i.msg_byte),
    .kinds_i    (kinds_q),
    .nxt_o      (nxt),
    .push_o     (push),
    .push_obj_o (push_obj),
    .emit_o     (emit)
  );

  assign in_ready_o = !sk_q;
  assign acc        = in_valid_i && in_ready_o;

  // verdict from the state after the last byte
  always_comb begin
    if (nxt.mode == PM_EMPTY) verdict = VerdictNone;
    else if (nxt.mode != PM_TAIL) verdict = VerdictBad;
    else if (!nxt.audio_evt) verdict = VerdictNone;
    else if (!nxt.delta_str || nxt.delta_bad || phase_q != 2'd0) verdict = VerdictBad;
    else verdict = VerdictAudio;
  end

  // result word and next counters
  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    phase_d = phase_q;
    res_vld = 1'b0;
    res     = '0;
    if (acc) begin
      if (in_data_i.is_last) begin
        res_vld            = 1'b1;
        res.kind           = 1'b1;
        res.verdict        = verdict;
        res.payload_length = (count_q > CountBits'(16'hFFFF)) ? 16'hFFFF : 16'(count_q);
        st_d    = rst_st;
        count_d = '0;
        phase_d = '0;
      end else begin
        st_d = nxt;
        if (emit && nxt.mode != PM_FAIL) begin
          res_vld          = 1'b1;
          res.payload_char = in_data_i.msg_byte;
          if (count_q != {CountBits{1'b1}}) count_d = count_q + 1'b1;
          phase_d = phase_q + 1'b1;
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= rst_st;
      count_q <= '0;
      phase_q <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  // container kind stack
  always_ff @(posedge clk_i) begin
    if (acc && push) kinds_q[IdxBits'(st_q.level)] <= push_obj;
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sk_q <= 1'b0;
    end else begin
      if (!ov_q || out_ready_i) begin
        ov_q <= sk_q || res_vld;
        sk_q <= 1'b0;
      end else if (res_vld) begin
        sk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) od_q <= sk_q ? sd_q : res;
    else if (res_vld) sd_q <= res;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // a skid entry only exists behind a full output register
  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni) sk_q |-> ov_q)
    else $error("skid entry valid with empty output register");
  // a stalled output word must not be overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(od_q))
    else $error("output word changed while stalled");
  // the parser state returns to start after a last byte
  a_last_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.is_last |=> st_q.mode == PM_START && count_q == '0)
    else $error("state not cleared after last byte");
  // nesting level never exceeds the stack
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.level <= LevelBits'(StackSize))
    else $error("nesting level beyond stack");

endmodule

>>> hw/rtl/jeafx_parser.sv
// Byte parser: next-state logic of the JSON grammar checker and delta extractor.
`timescale 1ns / 1ps
module jeafx_parser (
  input  jeafx_pkg::pstate_t                 cur_i,
  input  logic [7:0]                         b_i,
  input  logic [jeafx_pkg::StackSize-1:0]    kinds_i,
  output jeafx_pkg::pstate_t                 nxt_o,
  output logic                               push_o,
  output logic                               push_obj_o,
  output logic                               emit_o
);
  import jeafx_pkg::*;

  pstate_t s;
  logic    top_obj;
  logic    is_close;
  logic    is_sep;
  logic [IdxBits-1:0] top_idx;
  logic    do_content;
  logic [1:0] ckind;
  logic    miss_hit;

  assign top_idx  = IdxBits'(cur_i.level - 1'b1);
  assign is_close = b_i == "}" || b_i == "]";
  assign is_sep   = is_ws(b_i) || b_i == "," || is_close;

  always_comb begin
    s          = cur_i;
    push_o     = 1'b0;
    push_obj_o = 1'b0;
    emit_o     = 1'b0;
    do_content = 1'b0;
    ckind      = 2'd0;
    top_obj    = kinds_i[top_idx];
    miss_hit   = 1'b0;

    // structural step; object/array first and a token end fall through once
    if (s.mode == PM_OBJ_FIRST && !is_ws(b_i) && b_i != "}") s.mode = PM_KEY_START;
    if (s.mode == PM_ARR_FIRST && !is_ws(b_i) && b_i != "]") s.mode = PM_VALUE_START;
    if (s.mode == PM_TOKEN && is_sep) s.mode = PM_AFTER;

    unique case (s.mode)
      PM_START: begin
        if (!is_ws(b_i)) begin
          if (b_i == "{") begin
            push_o = 1'b1; push_obj_o = 1'b1;
            s.level = s.level + 1'b1; s.mode = PM_OBJ_FIRST;
          end else s.mode = PM_FAIL;
        end
      end
      PM_OBJ_FIRST: begin
        if (b_i == "}") begin
          if (s.level == LevelBits'(1)) s.mode = PM_EMPTY;
          else begin
            s.level = s.level - 1'b1;
            s.mode  = (s.level == '0) ? PM_TAIL : PM_AFTER;
          end
        end
      end
      PM_ARR_FIRST: begin
        if (b_i == "]") begin
          s.level = s.level - 1'b1;
          s.mode  = (s.level == '0) ? PM_TAIL : PM_AFTER;
        end
      end
      PM_KEY_START: begin
        if (!is_ws(b_i)) begin
          if (b_i == "\"") begin
            s.str_key = 1'b1; s.miss = 1'b0;
            s.sel = (s.level == LevelBits'(1)) ? SEL_KEY_ANY : SEL_NONE;
            s.key_pos = '0; s.val_pos = '0; s.mode = PM_STR;
          end else s.mode = PM_FAIL;
        end
      end
      PM_STR: begin
        if (b_i == "\"") begin
          // close string
          if (s.str_key) begin
            s.role = SEL_NONE; s.mode = PM_COLON;
            if (s.sel == SEL_KEY_TYPE && !s.miss && s.key_pos == 3'd4) begin
              if (s.got_type) s.mode = PM_FAIL;
              else begin s.got_type = 1'b1; s.role = SEL_TYPE_VAL; end
            end else if (s.sel == SEL_KEY_DELTA && !s.miss && s.key_pos == 3'd5) begin
              if (s.got_delta) s.mode = PM_FAIL;
              else begin s.got_delta = 1'b1; s.role = SEL_DELTA_VAL; end
            end
          end else begin
            if (s.sel == SEL_TYPE_VAL && !s.miss && s.val_pos == 5'd20) s.audio_evt = 1'b1;
            s.mode = PM_AFTER;
          end
          if (s.mode != PM_FAIL) s.sel = SEL_NONE;
        end else if (b_i < 8'd32) s.mode = PM_FAIL;
        else if (b_i == "\\") begin
          do_content = 1'b1; ckind = 2'd1; s.mode = PM_STR_ESC;
        end else begin
          do_content = 1'b1; ckind = 2'd0;
        end
      end
      PM_STR_ESC: begin
        if (b_i == "u") begin
          do_content = 1'b1; ckind = 2'd2; s.hex_left = 3'd4; s.mode = PM_STR_HEX;
        end else if (b_i == "\"" || b_i == "\\" || b_i == "/" || b_i == "b" ||
                     b_i == "f" || b_i == "n" || b_i == "r" || b_i == "t") begin
          do_content = 1'b1; ckind = 2'd2; s.mode = PM_STR;
        end else s.mode = PM_FAIL;
      end
      PM_STR_HEX: begin
        if (!is_hex(b_i)) s.mode = PM_FAIL;
        else begin
          do_content = 1'b1; ckind = 2'd3;
          if (s.hex_left != '0) s.hex_left = s.hex_left - 1'b1;
          if (s.hex_left == '0) s.mode = PM_STR;
        end
      end
      PM_COLON: begin
        if (!is_ws(b_i)) s.mode = (b_i == ":") ? PM_VALUE_START : PM_FAIL;
      end
      PM_VALUE_START: begin
        if (!is_ws(b_i)) begin
          if (s.level > LevelBits'(MaxNest + 1)) s.mode = PM_FAIL;
          else if (b_i == "\"") begin
            s.sel = (s.level == LevelBits'(1)) ? s.role : SEL_NONE;
            if (s.sel == SEL_DELTA_VAL) s.delta_str = 1'b1;
            s.str_key = 1'b0; s.miss = 1'b0;
            s.key_pos = '0; s.val_pos = '0; s.mode = PM_STR;
          end else if (b_i == "{" || b_i == "[") begin
            if (s.level >= LevelBits'(StackSize)) s.mode = PM_FAIL;
            else begin
              push_o = 1'b1; push_obj_o = (b_i == "{");
              s.level = s.level + 1'b1;
              s.mode  = (b_i == "{") ? PM_OBJ_FIRST : PM_ARR_FIRST;
            end
          end else if (b_i == "," || is_close) s.mode = PM_FAIL;
          else s.mode = PM_TOKEN;
        end
      end
      PM_TOKEN: ;
      PM_AFTER: begin
        if (!is_ws(b_i)) begin
          if (s.level == '0 || s.level > LevelBits'(StackSize)) s.mode = PM_FAIL;
          else if (b_i == ",") s.mode = top_obj ? PM_KEY_START : PM_VALUE_START;
          else if (b_i == (top_obj ? 8'h7d : 8'h5d)) begin
            s.level = s.level - 1'b1;
            s.mode  = (s.level == '0) ? PM_TAIL : PM_AFTER;
          end else s.mode = PM_FAIL;
        end
      end
      PM_TAIL: if (!is_ws(b_i)) s.mode = PM_FAIL;
      PM_FAIL, PM_EMPTY: ;
      default: s.mode = PM_FAIL;
    endcase

    // string content matching and delta capture
    if (do_content) begin
      if (s.sel == SEL_KEY_ANY)
        s.sel = (b_i == "t") ? SEL_KEY_TYPE : (b_i == "d") ? SEL_KEY_DELTA : SEL_NONE;
      if (s.sel == SEL_KEY_TYPE) begin
        if (!s.miss) begin
          if (s.key_pos < 3'd4 && b_i == type_chr(s.key_pos)) s.key_pos = s.key_pos + 1'b1;
          else miss_hit = 1'b1;
        end
      end else if (s.sel == SEL_KEY_DELTA) begin
        if (!s.miss) begin
          if (s.key_pos < 3'd5 && b_i == delta_chr(s.key_pos)) s.key_pos = s.key_pos + 1'b1;
          else miss_hit = 1'b1;
        end
      end else if (s.sel == SEL_TYPE_VAL) begin
        if (!s.miss) begin
          if (s.val_pos < 5'd20 && b_i == audio_chr(s.val_pos)) s.val_pos = s.val_pos + 1'b1;
          else miss_hit = 1'b1;
        end
      end else if (s.sel == SEL_DELTA_VAL && ckind != 2'd1) begin
        if ((ckind == 2'd0 && !is_b64(b_i)) || (ckind == 2'd2 && b_i != "/") || ckind == 2'd3)
          s.delta_bad = 1'b1;
        emit_o = 1'b1;
      end
      if (miss_hit) s.miss = 1'b1;
    end
    nxt_o = s;
  end

endmodule
